>>> hw/rtl/ook_pulse_width_capture_defines.svh
// Assertion macros for the pulse width capture RTL.
`ifndef OOK_PULSE_WIDTH_CAPTURE_DEFINES_SVH
`define OOK_PULSE_WIDTH_CAPTURE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property on an explicit clock and active-low reset.
`define OPWC_ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("opwc assertion failed");

// Check a property on the block clock and reset.
`define OPWC_ASSERT(label, prop) \
  `OPWC_ASSERT_CLK(label, clk_i, rst_ni, prop)

`else

`define OPWC_ASSERT_CLK(label, clk, rst_n, prop)
`define OPWC_ASSERT(label, prop)

`endif

`endif

>>> hw/rtl/opwc_pkg.sv
// Types and constants for the pulse width capture block.
`default_nettype none

package opwc_pkg;

  localparam int unsigned RunW   = 20;
  localparam int unsigned CountW = 16;
  localparam int unsigned CfgIdxW = 3;

  // Pulse limit for one capture
  localparam logic [CountW-1:0] MaxPulses = 16'd256;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgLeadHighTimeout = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgLeadHighMin     = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSyncLowTimeout  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSyncLowMin      = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPulseTimeout    = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgPulseMin        = 3'd5;

  // Configuration reset values
  localparam logic [RunW-1:0] RstLeadHighTimeout = 20'd5000;
  localparam logic [RunW-1:0] RstLeadHighMin     = 20'd150;
  localparam logic [RunW-1:0] RstSyncLowTimeout  = 20'd10000;
  localparam logic [RunW-1:0] RstSyncLowMin      = 20'd500;
  localparam logic [RunW-1:0] RstPulseTimeout    = 20'd500;
  localparam logic [RunW-1:0] RstPulseMin        = 20'd20;

  typedef enum logic [1:0] {
    KIND_PULSE = 2'd0,
    KIND_END   = 2'd1,
    KIND_FAIL  = 2'd2
  } kind_e;

  typedef struct packed {
    logic mode;
    logic level;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic              pulse_level;
    logic [RunW-1:0]   duration;
    logic [CountW-1:0] pulse_count;
    logic              last;
  } out_beat_t;

endpackage

`default_nettype wire

>>> hw/rtl/ook_pulse_width_capture.sv
// OOK pulse width capture: idle and sync detection, pulse recording.
//
// Input channel (in_valid_i / in_stall_o / in_data_i): one beat per timer
// tick carrying the sampled level, or a start command (mode = 1) that
// arms a new capture. Output channel (out_valid_o / out_stall_i /
// out_data_o): recorded pulses, a normal end or a failure, at most one
// beat per input beat. Configuration: cfg_we_i writes cfg_wdata_i to
// register cfg_idx_i; the user must write only while the block is idle,
// which the block itself does not enforce. Indexes past 5 are ignored.
// Throughput is one beat per cycle while the receiver does not stall. An
// accepted beat sits in the input register, where a single pass of
// counter, compare and phase logic updates the state and loads the
// result register, which drives the output channel.
// When the receiver stalls, the result register holds and the input
// register keeps taking one more beat; past that in_stall_o rises.
// Reset restores the register defaults, stops any capture and empties
// both registers.
`default_nettype none
`include "ook_pulse_width_capture_defines.svh"

module ook_pulse_width_capture (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [opwc_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [opwc_pkg::RunW-1:0]       cfg_wdata_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire opwc_pkg::in_beat_t              in_data_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output opwc_pkg::out_beat_t                  out_data_o
);

  typedef enum logic [2:0] {
    PH_STOP = 3'd0,
    PH_IDLE = 3'd1,
    PH_SYNC = 3'd2,
    PH_HIGH = 3'd3,
    PH_LOW  = 3'd4
  } phase_e;

  localparam logic [opwc_pkg::RunW-1:0] RunMax = '1;

  // Configuration registers
  logic [opwc_pkg::RunW-1:0] lead_high_timeout_q, lead_high_min_q;
  logic [opwc_pkg::RunW-1:0] sync_low_timeout_q, sync_low_min_q;
  logic [opwc_pkg::RunW-1:0] pulse_timeout_q, pulse_min_q;

  // Capture state
  phase_e                      phase_q, phase_d;
  logic [opwc_pkg::RunW-1:0]   run_q, run_d;
  logic [opwc_pkg::CountW-1:0] rec_q, rec_d;

  // Input and result registers
  logic                  in_valid_q;
  opwc_pkg::in_beat_t    in_q;
  logic                  out_valid_q;
  opwc_pkg::out_beat_t   out_q;

  logic                        out_free, advance, in_accept;
  logic                        res_valid;
  opwc_pkg::out_beat_t         res;
  logic                        watched;
  logic [opwc_pkg::RunW-1:0]   tmo, mn, run_inc;
  logic [opwc_pkg::CountW-1:0] rec_inc;

  // Handshake
  assign out_free    = !out_valid_q || !out_stall_i;
  assign advance     = in_valid_q && out_free;
  assign in_stall_o  = in_valid_q && !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Select the watched level and limits of the current phase
  always_comb begin
    unique case (phase_q)
      PH_IDLE: begin
        watched = 1'b1; tmo = lead_high_timeout_q; mn = lead_high_min_q;
      end
      PH_SYNC: begin
        watched = 1'b0; tmo = sync_low_timeout_q; mn = sync_low_min_q;
      end
      PH_HIGH: begin
        watched = 1'b1; tmo = pulse_timeout_q; mn = pulse_min_q;
      end
      PH_LOW: begin
        watched = 1'b0; tmo = pulse_timeout_q; mn = pulse_min_q;
      end
      default: begin
        watched = 1'b0; tmo = '0; mn = '0;
      end
    endcase
  end

  assign run_inc = (run_q == RunMax) ? run_q : run_q + 1'b1;
  assign rec_inc = rec_q + 1'b1;

  // Step the capture by one beat
  always_comb begin
    phase_d   = phase_q;
    run_d     = run_q;
    rec_d     = rec_q;
    res_valid = 1'b0;
    res       = '0;
    if (in_q.mode) begin
      phase_d = PH_IDLE;
      run_d   = '0;
      rec_d   = '0;
    end else if (phase_q == PH_STOP || phase_q == PH_IDLE || phase_q == PH_SYNC ||
                 phase_q == PH_HIGH || phase_q == PH_LOW) begin
      if (phase_q == PH_STOP) begin
        phase_d = PH_STOP;
      end else if (in_q.level == watched) begin
        run_d = run_inc;
        if (run_inc > tmo) begin
          phase_d   = PH_STOP;
          run_d     = '0;
          res_valid = 1'b1;
          res.last  = 1'b1;
          if (phase_q == PH_HIGH || phase_q == PH_LOW) begin
            res.kind        = opwc_pkg::KIND_END;
            res.pulse_count = rec_q;
          end else begin
            rec_d    = '0;
            res.kind = opwc_pkg::KIND_FAIL;
          end
        end
      end else if (run_q <= mn) begin
        run_d = '0;
      end else if (phase_q == PH_IDLE) begin
        phase_d = PH_SYNC;
        run_d   = opwc_pkg::RunW'(1);
      end else if (phase_q == PH_SYNC) begin
        phase_d = PH_HIGH;
        run_d   = opwc_pkg::RunW'(1);
      end else begin
        rec_d           = rec_inc;
        res_valid       = 1'b1;
        res.kind        = opwc_pkg::KIND_PULSE;
        res.pulse_level = watched;
        res.duration    = run_q;
        res.pulse_count = rec_inc;
        if (rec_inc >= opwc_pkg::MaxPulses) begin
          res.last = 1'b1;
          phase_d  = PH_STOP;
          run_d    = '0;
        end else begin
          phase_d = (phase_q == PH_HIGH) ? PH_LOW : PH_HIGH;
          run_d   = opwc_pkg::RunW'(1);
        end
      end
    end else begin
      phase_d = PH_STOP;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_high_timeout_q <= opwc_pkg::RstLeadHighTimeout;
      lead_high_min_q     <= opwc_pkg::RstLeadHighMin;
      sync_low_timeout_q  <= opwc_pkg::RstSyncLowTimeout;
      sync_low_min_q      <= opwc_pkg::RstSyncLowMin;
      pulse_timeout_q     <= opwc_pkg::RstPulseTimeout;
      pulse_min_q         <= opwc_pkg::RstPulseMin;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        opwc_pkg::CfgLeadHighTimeout: lead_high_timeout_q <= cfg_wdata_i;
        opwc_pkg::CfgLeadHighMin:     lead_high_min_q     <= cfg_wdata_i;
        opwc_pkg::CfgSyncLowTimeout:  sync_low_timeout_q  <= cfg_wdata_i;
        opwc_pkg::CfgSyncLowMin:      sync_low_min_q      <= cfg_wdata_i;
        opwc_pkg::CfgPulseTimeout:    pulse_timeout_q     <= cfg_wdata_i;
        opwc_pkg::CfgPulseMin:        pulse_min_q         <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Hold state, input beat and result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_STOP;
      run_q       <= '0;
      rec_q       <= '0;
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        phase_q <= phase_d;
        run_q   <= run_d;
        rec_q   <= rec_d;
      end
      if (in_accept) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= res_valid;
      end else if (out_free) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  `OPWC_ASSERT(a_stop_clears_run, (phase_q == PH_STOP) |-> (run_q == '0))
  `OPWC_ASSERT(a_rec_bounded, rec_q <= opwc_pkg::MaxPulses)
  `OPWC_ASSERT(a_last_stops, (advance && res_valid && res.last) |=> (phase_q == PH_STOP))
  `OPWC_ASSERT(a_fail_no_count,
    (out_valid_q && out_q.kind == opwc_pkg::KIND_FAIL) |-> (out_q.pulse_count == '0))
  `OPWC_ASSERT(a_stall_needs_beat, in_stall_o |-> in_valid_q)

endmodule

`default_nettype wire

>>> dv/tb.sv
// Testbench for the OOK pulse width capture block: directed table, random captures.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import opwc_pkg::*;

  typedef enum logic [2:0] {
    CAP_STOPPED = 3'd0,
    CAP_IDLE    = 3'd1,
    CAP_SYNC    = 3'd2,
    CAP_HIGH    = 3'd3,
    CAP_LOW     = 3'd4
  } capture_phase_e;

  // One input beat, optionally with an expectation typed in by hand
  typedef struct packed {
    in_beat_t  beat;
    logic      fixed;
    logic      has_res;
    out_beat_t res;
  } stim_row_t;

  typedef logic [RunW-1:0] reg_set_t [6];

  localparam int unsigned SHORT_RUN = 64;
  localparam logic [CfgIdxW-1:0] REG_IDX [6] = '{
    CfgLeadHighTimeout, CfgLeadHighMin, CfgSyncLowTimeout,
    CfgSyncLowMin, CfgPulseTimeout, CfgPulseMin
  };

  localparam stim_row_t START   = '{beat: '{mode: 1'b1, level: 1'b0},
                                    fixed: 1'b0, has_res: 1'b0, res: '0};
  localparam stim_row_t TICK_LO = '{beat: '{mode: 1'b0, level: 1'b0},
                                    fixed: 1'b0, has_res: 1'b0, res: '0};
  localparam stim_row_t TICK_HI = '{beat: '{mode: 1'b0, level: 1'b1},
                                    fixed: 1'b0, has_res: 1'b0, res: '0};

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [RunW-1:0]     cfg_wdata = '0;
  logic                tick_valid = 1'b0;
  logic                tick_stall;
  stim_row_t           cur_row = '0;
  logic                event_valid;
  logic                event_stall = 1'b0;
  out_beat_t           event_data;

  int unsigned         cyc_cnt = 0;
  int unsigned         mismatch_count = 0;

  // Predictor state and register copy
  capture_phase_e      cap_phase = CAP_STOPPED;
  logic [RunW-1:0]     run_ticks = '0;
  logic [CountW-1:0]   pulses_seen = '0;
  logic [RunW-1:0]     cfg_copy [6] = '{RstLeadHighTimeout, RstLeadHighMin, RstSyncLowTimeout,
                                        RstSyncLowMin, RstPulseTimeout, RstPulseMin};

  out_beat_t           pending_events [$];
  stim_row_t           stim_q [$];

  // Directed rows, run with lead timeout 4, lead min 1, sync timeout 4,
  // sync min 1, pulse timeout 3, pulse min 1
  stim_row_t opening_rows [25] = '{
    '{beat: '{mode: 1'b0, level: 1'b1}, fixed: 1'b1, has_res: 1'b0, res: '0},
    START,
    TICK_LO,
    TICK_HI, TICK_HI, TICK_LO,
    TICK_LO, TICK_HI,
    TICK_HI,
    '{beat: '{mode: 1'b0, level: 1'b0}, fixed: 1'b1, has_res: 1'b1,
      res: '{KIND_PULSE, 1'b1, 20'd2, 16'd1, 1'b0}},
    TICK_LO,
    '{beat: '{mode: 1'b0, level: 1'b1}, fixed: 1'b1, has_res: 1'b1,
      res: '{KIND_PULSE, 1'b0, 20'd2, 16'd2, 1'b0}},
    TICK_LO,
    TICK_HI, TICK_HI, TICK_HI,
    '{beat: '{mode: 1'b0, level: 1'b1}, fixed: 1'b1, has_res: 1'b1,
      res: '{KIND_END, 1'b0, 20'd0, 16'd2, 1'b1}},
    START, TICK_HI, START,
    TICK_HI, TICK_HI, TICK_HI, TICK_HI,
    '{beat: '{mode: 1'b0, level: 1'b1}, fixed: 1'b1, has_res: 1'b1,
      res: '{KIND_FAIL, 1'b0, 20'd0, 16'd0, 1'b1}}
  };

  ook_pulse_width_capture i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (tick_valid),
    .in_stall_o  (tick_stall),
    .in_data_i   (cur_row.beat),
    .out_valid_o (event_valid),
    .out_stall_i (event_stall),
    .out_data_o  (event_data)
  );

  always begin
    #5ns clk_i = 1'b1;
    #5ns clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cyc_cnt <= cyc_cnt + 1;
  end

  // Idle at random, except in a quiet stretch of every window
  function automatic bit idle_draw();
    if ((cyc_cnt % 3000) < 800) return 1'b0;
    return $urandom_range(99) < 22;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Advance the capture by one beat and work out the event it causes
  task automatic advance_capture(input in_beat_t b, output bit produced, output out_beat_t res);
    logic            watched;
    logic [RunW-1:0] tmo;
    logic [RunW-1:0] mn;
    produced = 1'b0;
    res = '0;
    if (b.mode) begin
      cap_phase = CAP_IDLE;
      run_ticks = '0;
      pulses_seen = '0;
      return;
    end
    case (cap_phase)
      CAP_IDLE: begin
        watched = 1'b1; tmo = cfg_copy[CfgLeadHighTimeout]; mn = cfg_copy[CfgLeadHighMin];
      end
      CAP_SYNC: begin
        watched = 1'b0; tmo = cfg_copy[CfgSyncLowTimeout]; mn = cfg_copy[CfgSyncLowMin];
      end
      CAP_HIGH: begin
        watched = 1'b1; tmo = cfg_copy[CfgPulseTimeout]; mn = cfg_copy[CfgPulseMin];
      end
      CAP_LOW: begin
        watched = 1'b0; tmo = cfg_copy[CfgPulseTimeout]; mn = cfg_copy[CfgPulseMin];
      end
      default: begin
        cap_phase = CAP_STOPPED;
        return;
      end
    endcase

    if (b.level == watched) begin
      // extend the run, saturating, then check the timeout
      if (run_ticks != '1) run_ticks++;
      if (run_ticks > tmo) begin
        produced = 1'b1;
        res.last = 1'b1;
        if (cap_phase == CAP_HIGH || cap_phase == CAP_LOW) begin
          res.kind = KIND_END;
        end else begin
          pulses_seen = '0;
          res.kind = KIND_FAIL;
        end
        res.pulse_count = pulses_seen;
        cap_phase = CAP_STOPPED;
        run_ticks = '0;
      end
    end else if (run_ticks <= mn) begin
      run_ticks = '0;
    end else if (cap_phase == CAP_IDLE) begin
      cap_phase = CAP_SYNC;
      run_ticks = RunW'(1);
    end else if (cap_phase == CAP_SYNC) begin
      cap_phase = CAP_HIGH;
      run_ticks = RunW'(1);
    end else begin
      // record the finished pulse
      produced = 1'b1;
      pulses_seen++;
      res.kind = KIND_PULSE;
      res.pulse_level = watched;
      res.duration = run_ticks;
      res.pulse_count = pulses_seen;
      if (pulses_seen >= MaxPulses) begin
        res.last = 1'b1;
        cap_phase = CAP_STOPPED;
        run_ticks = '0;
      end else begin
        cap_phase = (cap_phase == CAP_HIGH) ? CAP_LOW : CAP_HIGH;
        run_ticks = RunW'(1);
      end
    end
  endtask

  // Predict on accepted ticks, check accepted events
  always @(posedge clk_i) begin : monitor_b
    bit        produced;
    out_beat_t res;
    out_beat_t want;
    if (rst_ni) begin
      if (tick_valid && !tick_stall) begin
        advance_capture(cur_row.beat, produced, res);
        if (cur_row.fixed) begin
          produced = cur_row.has_res;
          res = cur_row.res;
        end
        if (produced) pending_events.push_back(res);
      end
      if (event_valid && !event_stall) begin
        if (pending_events.size() == 0) begin
          flag_mismatch($sformatf("event with none expected: %p", event_data));
        end else begin
          want = pending_events.pop_front();
          if (event_data.kind !== want.kind)
            flag_mismatch($sformatf("kind got %0d want %0d", event_data.kind, want.kind));
          if (event_data.pulse_level !== want.pulse_level)
            flag_mismatch($sformatf("pulse_level got %0d want %0d",
                                    event_data.pulse_level, want.pulse_level));
          if (event_data.duration !== want.duration)
            flag_mismatch($sformatf("duration got %0d want %0d",
                                    event_data.duration, want.duration));
          if (event_data.pulse_count !== want.pulse_count)
            flag_mismatch($sformatf("pulse_count got %0d want %0d",
                                    event_data.pulse_count, want.pulse_count));
          if (event_data.last !== want.last)
            flag_mismatch($sformatf("last got %0d want %0d", event_data.last, want.last));
        end
      end
    end
  end

  // Receiver stalls at random
  always @(posedge clk_i) begin
    event_stall <= idle_draw();
  end

  // Drive the queued rows; hold a stalled beat, idle at random between beats
  task automatic send_rows();
    int unsigned idx;
    idx = 0;
    while (idx < stim_q.size()) begin
      @(posedge clk_i);
      if (tick_valid && !tick_stall) idx++;
      if (tick_valid && tick_stall) begin
        // hold
      end else if (idx < stim_q.size() && !idle_draw()) begin
        tick_valid <= 1'b1;
        cur_row <= stim_q[idx];
      end else begin
        tick_valid <= 1'b0;
      end
    end
  endtask

  // Wait for every expected event, then let the pipeline drain
  task automatic settle();
    int unsigned waited;
    waited = 0;
    while (pending_events.size() != 0 && waited < 5000) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_events.size() != 0) begin
      flag_mismatch($sformatf("%0d events never arrived", pending_events.size()));
      pending_events.delete();
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic load_regs(input reg_set_t vals);
    for (int i = 0; i < 6; i++) begin
      @(posedge clk_i);
      cfg_we <= 1'b1;
      cfg_idx <= REG_IDX[i];
      cfg_wdata <= vals[i];
      cfg_copy[REG_IDX[i]] = vals[i];
    end
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  function automatic int unsigned run_length(input logic [RunW-1:0] mn,
                                             input logic [RunW-1:0] tmo);
    int unsigned pct;
    pct = $urandom_range(99);
    if (pct < 10) return $urandom_range(1, 3);
    if (pct < 22 && tmo < SHORT_RUN) return tmo + $urandom_range(1, 3);
    if (mn < SHORT_RUN) return mn + $urandom_range(1, 4);
    return $urandom_range(1, 8);
  endfunction

  task automatic push_ticks(input logic lvl, input int unsigned n);
    repeat (n) stim_q.push_back(lvl ? TICK_HI : TICK_LO);
  endtask

  // Build captures: mostly well-formed trains, some noise
  task automatic build_captures(input int unsigned budget, input int unsigned plo,
                                input int unsigned phi);
    int unsigned pulses;
    logic        lvl;
    stim_row_t   noise;
    while (stim_q.size() < budget) begin
      if ($urandom_range(99) < 8) begin
        repeat ($urandom_range(1, 10)) begin
          noise = TICK_LO;
          noise.beat.mode = ($urandom_range(9) == 0);
          noise.beat.level = 1'($urandom_range(1));
          stim_q.push_back(noise);
        end
      end else begin
        stim_q.push_back(START);
        push_ticks(1'b0, $urandom_range(0, 2));
        push_ticks(1'b1, run_length(cfg_copy[CfgLeadHighMin], cfg_copy[CfgLeadHighTimeout]));
        push_ticks(1'b0, run_length(cfg_copy[CfgSyncLowMin], cfg_copy[CfgSyncLowTimeout]));
        pulses = $urandom_range(plo, phi);
        lvl = 1'b1;
        repeat (pulses + 1) begin
          push_ticks(lvl, run_length(cfg_copy[CfgPulseMin], cfg_copy[CfgPulseTimeout]));
          lvl = !lvl;
        end
      end
    end
  endtask

  task automatic run_phase(input reg_set_t vals, input int unsigned budget,
                           input int unsigned plo, input int unsigned phi);
    settle();
    load_regs(vals);
    stim_q.delete();
    build_captures(budget, plo, phi);
    send_rows();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed table
    load_regs('{20'd4, 20'd1, 20'd4, 20'd1, 20'd3, 20'd1});
    stim_q.delete();
    foreach (opening_rows[i]) stim_q.push_back(opening_rows[i]);
    send_rows();

    // random captures over several register settings
    run_phase('{20'd6, 20'd2, 20'd8, 20'd2, 20'd6, 20'd2}, 300, 1, 12);
    run_phase('{20'd1, 20'd0, 20'd1, 20'd0, 20'd1, 20'd0}, 150, 1, 12);
    run_phase('{20'hFFFFF, 20'd3, 20'hFFFFF, 20'd3, 20'hFFFFF, 20'd0}, 700, 280, 300);
    run_phase('{20'd40, 20'd10, 20'd40, 20'd10, 20'd25, 20'd5}, 300, 1, 12);
    run_phase('{20'd12, 20'hFFFFF, 20'd12, 20'hFFFFF, 20'd12, 20'hFFFFF}, 75, 1, 12);
    settle();

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

>>> files.f
+incdir+hw/rtl
hw/rtl/opwc_pkg.sv
hw/rtl/ook_pulse_width_capture.sv
dv/tb.sv
